>>> rtl/core/srwg_pkg.sv
package srwg_pkg;

	// SplitMix64 constants
	localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;
	localparam int          MIX_SHIFT_A = 30;
	localparam int          MIX_SHIFT_B = 27;
	localparam int          MIX_SHIFT_C = 31;

	// xoshiro256** constants
	localparam int          XO_SHIFT    = 17;
	localparam int          XO_ROT_OUT  = 7;
	localparam int          XO_ROT_S3   = 45;

	// configuration register indexes
	typedef enum logic {
		CFG_SEED   = 1'b0,
		CFG_SELECT = 1'b1
	} cfg_index_t;

	// request handed from front to back
	typedef struct packed {
		logic valid;
		logic two;
	} req_t;

endpackage

>>> rtl/core/seeded_random_word_generator.sv
// Seeded random word generator: SplitMix64 or xoshiro256** words on request.
// Input channel (in_valid/in_ready, word_count): one request asks for one
// word (1) or two words (2 or 3); a request of 0 is taken and dropped.
// Output channel (out_valid/out_ready, random_word, last_word): one word per
// handshake, last_word marks the final word of a request.
// Config port: cfg_write with cfg_index 0 loads the seed into the SplitMix
// counter and forces a reseed of xoshiro; index 1 picks the generator
// (0 SplitMix64, 1 xoshiro256**). Write only while the block is idle.
// Structure: requests queue two deep in the front end; the back end makes
// words one at a time. A SplitMix word is one add, then two 64-bit
// constant multiplies of three partial products each on a single 32x32
// multiplier. A xoshiro word runs through states XO_A and XO_B; the first
// one after reset or a seed write waits while four SplitMix words fill the
// four state words. A request is popped from the queue in the idle state.
// Reset: counter 0, xoshiro selected and unseeded, queue and output empty.
// A stalled receiver holds the word in the output register; the back end
// finishes its next word and waits, and the queue keeps accepting requests until full.
module seeded_random_word_generator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           word_count,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [63:0]          random_word,
	output logic                 last_word,
	input  logic                 cfg_write,
	input  srwg_pkg::cfg_index_t cfg_index,
	input  logic [63:0]          cfg_data
);

	srwg_pkg::req_t req;
	logic           req_pop;

	// front: accept, drop empty requests, queue
	srwg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.word_count (word_count),
		.req        (req),
		.req_pop    (req_pop)
	);

	// back: generator state, shared multiplier, output register
	srwg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req         (req),
		.req_pop     (req_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.random_word (random_word),
		.last_word   (last_word)
	);

endmodule

>>> rtl/core/srwg_front.sv
module srwg_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      word_count,
	output srwg_pkg::req_t  req,
	input  logic            req_pop
);

	// two-entry request queue; an entry holds "two words" flag
	logic       q_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2);
	// a zero-word request is dropped here; 3 is treated as 2
	assign push     = in_valid && in_ready && (word_count != 2'd0);
	assign req.valid = (cnt_q != 2'd0);
	assign req.two   = q_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (req_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !req_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (!push && req_pop)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_q[wr_ptr_q] <= word_count[1];
	end

endmodule

>>> rtl/core/srwg_back.sv
module srwg_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  srwg_pkg::cfg_index_t cfg_index,
	input  logic [63:0]          cfg_data,
	input  srwg_pkg::req_t       req,
	output logic                 req_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [63:0]          random_word,
	output logic                 last_word
);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_MIX_ADD = 7'b0000010,
		ST_MUL_0   = 7'b0000100,
		ST_MUL_1   = 7'b0001000,
		ST_MUL_2   = 7'b0010000,
		ST_XO_A    = 7'b0100000,
		ST_XO_B    = 7'b1000000
	} state_t;

	state_t      state_q;
	state_t      start_state;
	logic [63:0] ctr_q;
	logic        sel_q;
	logic        xo_ready_q;
	logic [63:0] xo_q [4];
	logic [1:0]  seed_idx_q;
	logic        pass_q;
	logic        second_q;
	logic [63:0] z_q;
	logic [63:0] acc_q;
	logic [63:0] t_q;
	logic        out_valid_q;
	logic [63:0] out_word_q;
	logic        out_last_q;

	logic        out_free;
	logic        seeding;
	logic [63:0] mul_k;
	logic [31:0] a_op;
	logic [31:0] b_op;
	logic [63:0] prod;
	logic [63:0] acc_fin;
	logic [63:0] mix_word;
	logic [63:0] ctr_next;
	logic [63:0] rot_t;
	logic [63:0] xo_word;
	logic [63:0] s2_x;
	logic [63:0] s3_x;

	assign out_free    = !out_valid_q || out_ready;
	assign seeding     = sel_q && !xo_ready_q;
	assign start_state = (sel_q && xo_ready_q) ? ST_XO_A : ST_MIX_ADD;
	assign req_pop     = (state_q == ST_IDLE) && req.valid;

	// shared 32x32 multiplier: low 64 bits of z*k from three partial products
	assign mul_k   = pass_q ? srwg_pkg::MIX_MUL_B : srwg_pkg::MIX_MUL_A;
	assign a_op    = (state_q == ST_MUL_1) ? z_q[63:32] : z_q[31:0];
	assign b_op    = (state_q == ST_MUL_2) ? mul_k[63:32] : mul_k[31:0];
	assign prod    = 64'(a_op) * 64'(b_op);
	assign acc_fin = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
	assign mix_word = acc_fin ^ (acc_fin >> srwg_pkg::MIX_SHIFT_C);
	assign ctr_next = ctr_q + srwg_pkg::GOLDEN_STEP;

	// t_q = s1*5; out = rotl(t,7)*9
	assign rot_t   = (t_q << srwg_pkg::XO_ROT_OUT) | (t_q >> (64 - srwg_pkg::XO_ROT_OUT));
	assign xo_word = rot_t + {rot_t[60:0], 3'b000};
	assign s2_x    = xo_q[2] ^ xo_q[0];
	assign s3_x    = xo_q[3] ^ xo_q[1];

	assign out_valid   = out_valid_q;
	assign random_word = out_word_q;
	assign last_word   = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ctr_q       <= 64'd0;
			sel_q       <= 1'b1;
			xo_ready_q  <= 1'b0;
			seed_idx_q  <= 2'd0;
			pass_q      <= 1'b0;
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						second_q   <= req.two;
						seed_idx_q <= 2'd0;
						state_q    <= start_state;
					end
				end
				ST_MIX_ADD: begin
					ctr_q   <= ctr_next;
					pass_q  <= 1'b0;
					state_q <= ST_MUL_0;
				end
				ST_MUL_0: state_q <= ST_MUL_1;
				ST_MUL_1: state_q <= ST_MUL_2;
				ST_MUL_2: begin
					if (!pass_q) begin
						pass_q  <= 1'b1;
						state_q <= ST_MUL_0;
					end else if (seeding) begin
						seed_idx_q <= seed_idx_q + 2'd1;
						if (seed_idx_q == 2'd3) begin
							xo_ready_q <= 1'b1;
							state_q    <= ST_XO_A;
						end else begin
							state_q <= ST_MIX_ADD;
						end
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						second_q    <= 1'b0;
						state_q     <= second_q ? start_state : ST_IDLE;
					end
				end
				ST_XO_A: state_q <= ST_XO_B;
				ST_XO_B: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						second_q    <= 1'b0;
						state_q     <= second_q ? start_state : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// writes must arrive only while idle; the user ensures it, the block does not enforce it
			if (cfg_write) begin
				unique case (cfg_index)
					srwg_pkg::CFG_SEED: begin
						ctr_q      <= cfg_data;
						xo_ready_q <= 1'b0;
					end
					srwg_pkg::CFG_SELECT: sel_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_MIX_ADD: z_q <= ctr_next ^ (ctr_next >> srwg_pkg::MIX_SHIFT_A);
			ST_MUL_0:   acc_q <= prod;
			ST_MUL_1:   acc_q <= acc_fin;
			ST_MUL_2: begin
				if (!pass_q) begin
					z_q <= acc_fin ^ (acc_fin >> srwg_pkg::MIX_SHIFT_B);
				end else if (seeding) begin
					xo_q[seed_idx_q] <= mix_word;
				end else if (out_free) begin
					out_word_q <= mix_word;
					out_last_q <= !second_q;
				end
			end
			ST_XO_A: t_q <= xo_q[1] + {xo_q[1][61:0], 2'b00};
			ST_XO_B: begin
				if (out_free) begin
					out_word_q <= xo_word;
					out_last_q <= !second_q;
					xo_q[0] <= xo_q[0] ^ s3_x;
					xo_q[1] <= xo_q[1] ^ s2_x;
					xo_q[2] <= s2_x ^ (xo_q[1] << srwg_pkg::XO_SHIFT);
					xo_q[3] <= (s3_x << srwg_pkg::XO_ROT_S3) |
						(s3_x >> (64 - srwg_pkg::XO_ROT_S3));
				end
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/core/srwg_checker.sv
module srwg_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic [1:0]           word_count,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [63:0]          random_word,
	input logic                 last_word
);

	// words owed to the receiver
	logic [2:0] pending_q;
	logic [2:0] add_words;
	logic [2:0] sub_words;

	assign add_words = !(in_valid && in_ready) ? 3'd0 :
		(word_count[1] ? 3'd2 : {2'b00, word_count[0]});
	assign sub_words = {2'b00, out_valid && out_ready};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= 3'd0;
		else
			pending_q <= pending_q + add_words - sub_words;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(random_word) && $stable(last_word))
		else $error("stalled word changed");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("word without request");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 3'd0 |-> in_ready)
		else $error("not ready while drained");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |-> pending_q >= 3'd2)
		else $error("non-final word with nothing after it");

endmodule

bind seeded_random_word_generator srwg_checker u_srwg_checker (.*);
